FILE: sv/lds_pkg.sv
package lds_pkg;

   localparam int MAX_REQUESTS = 32;
   localparam int BLOCK_COUNT  = 200;

   localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int BLOCK_W = 8;
   localparam int MOVED_W = 9;

   localparam logic REQ_KIND_HEAD = 1'b0;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_HEAD,
      CMD_ADD
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [BLOCK_W-1:0] blk;
      logic               last;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HEAD,
      ST_UP,
      ST_DOWN
   } back_state_type;

endpackage

FILE: sv/lds_front.sv
module lds_front (
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // block
   input  logic                     req_tuser,   // req_type
   input  logic                     req_tlast,   // batch_end
   output logic                     push_valid,
   input  logic                     push_ready,
   output lds_pkg::cmd_type         push_cmd
);
   import lds_pkg::*;

   logic in_range;

   always_comb begin
      in_range        = 32'(req_tdata) < BLOCK_COUNT;
      push_valid      = req_tvalid;
      req_tready      = push_ready;
      push_cmd.blk    = req_tdata;
      push_cmd.last   = req_tlast;
      if (!in_range) begin
         push_cmd.kind = CMD_NONE;
      end else if (req_tuser == REQ_KIND_HEAD) begin
         push_cmd.kind = CMD_HEAD;
      end else begin
         push_cmd.kind = CMD_ADD;
      end
   end

endmodule

FILE: sv/lds_queue.sv
module lds_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  lds_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output lds_pkg::cmd_type pop_cmd
);
   import lds_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     fill_ff, fill_in;
   logic                do_push, do_pop;

   always_comb begin
      push_ready = fill_ff != (QPTR_W+1)'(QUEUE_DEPTH);
      pop_valid  = fill_ff != '0;
      pop_cmd    = entry_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;
      wr_ptr_in  = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in    = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: sv/lds_back.sv
module lds_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  lds_pkg::cmd_type pop_cmd,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [23:0]      rsp_tdata,   // served_block, moved_so_far, zero pad
   output logic             rsp_tuser,   // lost_requests
   output logic             rsp_tlast    // final_res
);
   import lds_pkg::*;

   back_state_type        state_ff, state_in;
   logic [BLOCK_W-1:0]    store_ff [MAX_REQUESTS];
   logic [BLOCK_W-1:0]    store_in [MAX_REQUESTS];
   logic                  store_we;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      below_ff, below_in;
   logic [BLOCK_W-1:0]    head_ff, head_in;
   logic                  ovf_ff, ovf_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;

   logic                  out_valid_ff, out_valid_in;
   logic [BLOCK_W-1:0]    out_block_ff, out_block_in;
   logic [MOVED_W-1:0]    out_moved_ff, out_moved_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_lost_ff, out_lost_in;

   logic                  slot_free;
   logic [MAX_REQUESTS-1:0] greater;
   logic [BLOCK_W-1:0]    rd_value;
   logic [BLOCK_W-1:0]    step;
   logic [MOVED_W:0]      moved_sum;
   logic [MOVED_W-1:0]    moved_next;
   logic [CNT_W-1:0]      last_pos;
   logic [CNT_W-1:0]      below_dec;
   logic                  at_top;

   // sorted insert: entries above the new value move up by one
   always_comb begin
      for (int i = 0; i < MAX_REQUESTS; i++) begin
         greater[i] = (CNT_W'(i) < count_ff) && (store_ff[i] > pop_cmd.blk);
      end
      for (int i = 0; i < MAX_REQUESTS; i++) begin
         if (i > 0 && greater[(i > 0) ? i - 1 : 0]) begin
            store_in[i] = store_ff[(i > 0) ? i - 1 : 0];
         end else if (greater[i] || CNT_W'(i) == count_ff) begin
            store_in[i] = pop_cmd.blk;
         end else begin
            store_in[i] = store_ff[i];
         end
      end
   end

   always_comb begin
      slot_free  = !out_valid_ff || rsp_tready;
      rd_value   = store_ff[idx_ff];
      step       = (rd_value >= out_block_ff) ? rd_value - out_block_ff
                                              : out_block_ff - rd_value;
      moved_sum  = {1'b0, out_moved_ff} + (MOVED_W+1)'(step);
      moved_next = moved_sum[MOVED_W] ? '1 : moved_sum[MOVED_W-1:0];
      last_pos   = count_ff - 1'b1;
      below_dec  = below_ff - 1'b1;
      at_top     = CNT_W'(idx_ff) == last_pos;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      below_in     = below_ff;
      head_in      = head_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      store_we     = 1'b0;
      pop_ready    = 1'b0;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_block_in = out_block_ff;
      out_moved_in = out_moved_ff;
      out_last_in  = out_last_ff;
      out_lost_in  = out_lost_ff;

      case (state_ff)
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               case (pop_cmd.kind)
                  CMD_HEAD: begin
                     head_in  = pop_cmd.blk;
                     count_in = '0;
                     below_in = '0;
                     ovf_in   = 1'b0;
                  end
                  CMD_ADD: begin
                     if (count_ff < CNT_W'(MAX_REQUESTS)) begin
                        store_we = 1'b1;
                        count_in = count_ff + 1'b1;
                        if (pop_cmd.blk < head_ff) begin
                           below_in = below_ff + 1'b1;
                        end
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               if (pop_cmd.last) begin
                  state_in = ST_HEAD;
               end
            end
         end
         ST_HEAD: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_block_in = head_ff;
               out_moved_in = '0;
               out_lost_in  = ovf_ff;
               out_last_in  = count_ff == '0;
               if (count_ff == '0) begin
                  state_in = ST_IDLE;
               end else if (below_ff < count_ff) begin
                  idx_in   = below_ff[IDX_W-1:0];
                  state_in = ST_UP;
               end else begin
                  idx_in   = below_dec[IDX_W-1:0];
                  state_in = ST_DOWN;
               end
            end
         end
         ST_UP: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_block_in = rd_value;
               out_moved_in = moved_next;
               out_last_in  = at_top && below_ff == '0;
               if (!at_top) begin
                  idx_in = idx_ff + 1'b1;
               end else if (below_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = below_dec[IDX_W-1:0];
                  state_in = ST_DOWN;
               end
            end
         end
         ST_DOWN: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_block_in = rd_value;
               out_moved_in = moved_next;
               out_last_in  = idx_ff == '0;
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         below_ff     <= '0;
         head_ff      <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         below_ff     <= below_in;
         head_ff      <= head_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      out_block_ff <= out_block_in;
      out_moved_ff <= out_moved_in;
      out_last_ff  <= out_last_in;
      out_lost_ff  <= out_lost_in;
      if (store_we) begin
         for (int i = 0; i < MAX_REQUESTS; i++) begin
            store_ff[i] <= store_in[i];
         end
      end
   end

   always_comb begin
      rsp_tvalid = out_valid_ff;
      rsp_tdata  = {(24 - BLOCK_W - MOVED_W)'(0), out_moved_ff, out_block_ff};
      rsp_tuser  = out_lost_ff;
      rsp_tlast  = out_last_ff;
   end

endmodule

FILE: sv/look_disk_scheduler_unit.sv
// LOOK disk scheduler.
// req channel: one beat per item. tdata[7:0] is the block, tuser is the kind
// (0 sets the head and clears the batch, 1 adds a request), tlast ends a batch.
// Blocks of 200 and up are ignored. Up to 32 requests are kept in sorted order.
// rsp channel: on a tlast beat the access order is sent: the head, then the
// requests at or above it ascending, then those below it descending.
// tdata[7:0] block, tdata[16:8] movement so far, tuser set when a request was
// dropped for lack of space, tlast on the last beat of the order.
// Timing: a four-entry queue decouples the request side from the sorter. The
// sorter takes one queued item per cycle while idle (each add is a sorted
// insert); a tlast item then keeps it busy until the whole order is sent,
// one result at a time through the single read port on the store. The first
// result beat passes the queue, the head state and the rsp register.
// rsp is registered; while rsp_tready is low the result holds and the sorter
// waits, and req keeps being accepted until the queue is full.
// Reset empties the queue and the batch, with the head at block 0.
module look_disk_scheduler_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // block
   input  logic        req_tuser,   // req_type
   input  logic        req_tlast,   // batch_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // served_block [7:0], moved_so_far [16:8], zero pad
   output logic        rsp_tuser,   // lost_requests
   output logic        rsp_tlast    // final_res
);
   import lds_pkg::*;

   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;

   lds_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   lds_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   lds_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: sv/lds_checker.sv
module lds_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   // no beat may appear straight out of reset
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result beat right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped while stalled");

   a_block_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:0] < 8'd200)
      else $error("served block out of range");

   a_moved_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[16:8] <= 9'd398 && rsp_tdata[23:17] == 7'd0)
      else $error("movement out of range");

   // a beat straight after an order ends is a head beat with no movement
   a_head_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast ##1 rsp_tvalid
         |-> rsp_tdata[16:8] == 9'd0)
      else $error("head beat carries movement");

endmodule

bind look_disk_scheduler_unit lds_checker u_lds_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

FILE: verif/look_disk_scheduler_unit_tb.sv
`timescale 1ns / 100ps

module look_disk_scheduler_unit_tb;
   import lds_pkg::*;

   localparam logic KIND_ADD       = ~REQ_KIND_HEAD;
   localparam int   HOLD_CYCLES    = 300;
   localparam int   WATCHDOG_LIMIT = 2000;
   localparam int   DRAIN_CYCLES   = 60;
   localparam int   PRINT_CAP      = 40;

   typedef struct packed {
      logic [BLOCK_W-1:0] blk;
      logic [MOVED_W-1:0] moved;
      logic               last;
      logic               lost;
   } access_step_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   // scheduler state as predicted
   logic [BLOCK_W-1:0] queued_blocks[$];
   logic [BLOCK_W-1:0] head_pos = '0;
   logic               lost_flag = 1'b0;
   access_step_type    expected_order[$];

   int mismatch_count = 0;
   bit hold_go = 1'b0;
   bit no_idle = 1'b0;

   look_disk_scheduler_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic flag_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
   endtask

   function automatic access_step_type step_at(input int blk, input int moved);
      access_step_type s;
      s.blk   = blk[BLOCK_W-1:0];
      s.moved = (moved > 511) ? 9'd511 : moved[MOVED_W-1:0];
      s.last  = 1'b0;
      s.lost  = lost_flag;
      return s;
   endfunction

   // update the predicted state with one accepted beat; on batch end, queue the LOOK order
   task automatic schedule_look(input logic kind, input logic [7:0] blk, input logic last);
      access_step_type walk[$];
      int pos;
      int moved;
      int prev;
      int v;
      if (blk < BLOCK_COUNT) begin
         if (kind == REQ_KIND_HEAD) begin
            head_pos = blk;
            queued_blocks.delete();
            lost_flag = 1'b0;
         end else if (queued_blocks.size() < MAX_REQUESTS) begin
            pos = queued_blocks.size();
            while (pos > 0 && queued_blocks[pos-1] > blk) pos--;
            queued_blocks.insert(pos, blk);
         end else begin
            lost_flag = 1'b1;
         end
      end
      if (!last) return;
      prev = head_pos;
      moved = 0;
      walk.push_back(step_at(prev, moved));
      pos = 0;
      while (pos < queued_blocks.size() && queued_blocks[pos] < head_pos) pos++;
      for (int i = pos; i < queued_blocks.size(); i++) begin
         v = queued_blocks[i];
         moved += (v >= prev) ? v - prev : prev - v;
         prev = v;
         walk.push_back(step_at(v, moved));
      end
      for (int i = pos; i > 0; i--) begin
         v = queued_blocks[i-1];
         moved += (v >= prev) ? v - prev : prev - v;
         prev = v;
         walk.push_back(step_at(v, moved));
      end
      walk[walk.size()-1].last = 1'b1;
      foreach (walk[i]) expected_order.push_back(walk[i]);
   endtask

   task automatic send_item(input logic kind, input logic [7:0] blk, input logic last);
      while (!no_idle && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= blk;
      req_tuser  <= kind;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      schedule_look(kind, blk, last);
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(99) >= 6);
         end
      end
   end

   always @(posedge clock) begin
      access_step_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_order.size() == 0) begin
            flag_mismatch("unexpected beat, block", rsp_tdata[7:0], 0);
         end else begin
            want = expected_order.pop_front();
            if (rsp_tdata[7:0] !== want.blk)
               flag_mismatch("served_block", rsp_tdata[7:0], want.blk);
            if (rsp_tdata[16:8] !== want.moved)
               flag_mismatch("moved_so_far", rsp_tdata[16:8], want.moved);
            if (rsp_tlast !== want.last)
               flag_mismatch("final_res", rsp_tlast, want.last);
            if (rsp_tuser !== want.lost)
               flag_mismatch("lost_requests", rsp_tuser, want.lost);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic test_extremes();
      send_item(REQ_KIND_HEAD, 8'd0, 1'b1);
      send_item(REQ_KIND_HEAD, 8'd199, 1'b0);
      send_item(KIND_ADD, 8'd199, 1'b0);
      send_item(KIND_ADD, 8'd0, 1'b0);
      send_item(KIND_ADD, 8'd199, 1'b0);
      send_item(KIND_ADD, 8'd0, 1'b1);
   endtask

   task automatic test_out_of_range();
      send_item(REQ_KIND_HEAD, 8'd200, 1'b1);
      send_item(KIND_ADD, 8'd255, 1'b1);
      send_item(REQ_KIND_HEAD, 8'd100, 1'b0);
      send_item(KIND_ADD, 8'd200, 1'b0);
      send_item(KIND_ADD, 8'd150, 1'b1);
   endtask

   task automatic test_head_match();
      send_item(REQ_KIND_HEAD, 8'd50, 1'b0);
      send_item(KIND_ADD, 8'd50, 1'b0);
      send_item(KIND_ADD, 8'd49, 1'b0);
      send_item(KIND_ADD, 8'd50, 1'b0);
      send_item(KIND_ADD, 8'd51, 1'b1);
   endtask

   task automatic test_empty_batch();
      send_item(REQ_KIND_HEAD, 8'd120, 1'b1);
      // state survives emission
      send_item(KIND_ADD, 8'd7, 1'b1);
   endtask

   task automatic test_back_pressure();
      hold_go = 1'b1;
      for (int b = 0; b < 3; b++) begin
         send_item(REQ_KIND_HEAD, 8'($urandom_range(0, 199)), 1'b0);
         for (int k = 0; k < 8; k++)
            send_item(KIND_ADD, 8'($urandom_range(0, 199)), k == 7);
      end
   endtask

   task automatic run_random_batches(input int item_goal);
      int counted;
      int n_req;
      int batch_no;
      logic [7:0] cur_head;
      logic [7:0] blk;
      logic last;
      counted = 0;
      batch_no = 0;
      cur_head = head_pos;
      while (counted < item_goal) begin
         if (batch_no == 0 || $urandom_range(99) < 8)
            n_req = $urandom_range(30, 40);
         else
            n_req = $urandom_range(0, 8);
         if ($urandom_range(99) < 6)
            send_item(REQ_KIND_HEAD, 8'($urandom_range(200, 255)), $urandom_range(99) < 20);
         if ($urandom_range(99) < 92) begin
            cur_head = 8'($urandom_range(0, 199));
            send_item(REQ_KIND_HEAD, cur_head, n_req == 0 || $urandom_range(99) < 4);
            counted++;
         end
         for (int k = 0; k < n_req; k++) begin
            case ($urandom_range(9))
               0: blk = 8'($urandom_range(200, 255));
               1: blk = cur_head;
               2: blk = $urandom_range(1) ? 8'd0 : 8'd199;
               default: blk = 8'($urandom_range(0, 199));
            endcase
            last = (k == n_req - 1) || ($urandom_range(99) < 3);
            send_item(KIND_ADD, blk, last);
            if (blk < BLOCK_COUNT) counted++;
         end
         batch_no++;
      end
   endtask

   task automatic test_full_rate();
      no_idle = 1'b1;
      run_random_batches(70);
      no_idle = 1'b0;
   endtask

   task automatic test_random_batches();
      run_random_batches(310);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_out_of_range();
      test_head_match();
      test_empty_batch();
      test_back_pressure();
      test_full_rate();
      test_random_batches();
      req_tvalid <= 1'b0;
      while (expected_order.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
